[src/ptcm_pkg.sv]
// ============================================================================
// ptcm_pkg - shared types and constants for the tone channel mixer
// Register map, the per-channel control bundle and the volume ROM.
// ============================================================================
`default_nettype none

package ptcm_pkg;

    localparam int unsigned MAX_CHANNELS     = 3;
    localparam int unsigned CHANNELS_DEFAULT = 3;

    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned PERIOD_W = 12;
    localparam int unsigned LEVEL_W  = 4;
    localparam int unsigned AMP_W    = 14;
    localparam int unsigned SAMPLE_W = 15;

    // Input kinds (tuser bit 0) and bus ports (tuser bit 1)
    localparam logic ACTION_BUS  = 1'b0;
    localparam logic ACTION_TICK = 1'b1;
    localparam logic PORT_ADDR   = 1'b0;
    localparam logic PORT_DATA   = 1'b1;

    // Register map
    localparam logic [ADDR_W-1:0] REG_PERIOD_BASE = 4'd0;
    localparam logic [ADDR_W-1:0] REG_MIXER       = 4'd7;
    localparam logic [ADDR_W-1:0] REG_LEVEL_BASE  = 4'd8;

    typedef struct packed {
        logic              tick;
        logic              wr_period_lo;
        logic              wr_period_hi;
        logic              wr_mixer;
        logic              wr_level;
        logic [DATA_W-1:0] data;
    } ch_ctrl_t;

    // Logarithmic volume table, 3 dB per step
    function automatic logic [AMP_W-1:0] vol_rom(input logic [LEVEL_W-1:0] level);
        logic [AMP_W-1:0] amp;
        case (level)
            4'd0:    amp = 14'd0;
            4'd1:    amp = 14'd64;
            4'd2:    amp = 14'd91;
            4'd3:    amp = 14'd128;
            4'd4:    amp = 14'd181;
            4'd5:    amp = 14'd256;
            4'd6:    amp = 14'd362;
            4'd7:    amp = 14'd512;
            4'd8:    amp = 14'd724;
            4'd9:    amp = 14'd1024;
            4'd10:   amp = 14'd1448;
            4'd11:   amp = 14'd2048;
            4'd12:   amp = 14'd2896;
            4'd13:   amp = 14'd4096;
            4'd14:   amp = 14'd5793;
            4'd15:   amp = 14'd8192;
            default: amp = 14'd0;
        endcase
        return amp;
    endfunction

endpackage

`default_nettype wire

[src/psg_tone_channel_mixer.sv]
// ============================================================================
// psg_tone_channel_mixer - three-channel square-wave tone generator and mixer
// Bus writes program tone periods, disable bits and volumes; ticks advance
// the tone counters. Every input transfer yields one mixed sample.
// ============================================================================
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  s_*     | in        | s_tvalid / s_tready | tdata: bus_data[7:0]
//          |           |                     | tuser: action[0], port_select[1]
//  m_*     | out       | m_tvalid / m_tready | tdata: sample_sum[14:0], 0[15]
//
//  One input transfer per cycle while s_tready is high; each transfer updates
//  the channel state and loads its sample into the output register at the same
//  edge, so the sample is offered from the next cycle.
//  The output register takes a new sample whenever it is empty or being
//  drained, so s_tready = !m_tvalid || m_tready and stalls pass straight back.
//  rst_n (asynchronous, active low) clears all channel state and the address
//  latch to zero and empties the output register.
// ============================================================================
`default_nettype none

module psg_tone_channel_mixer #(
    parameter int unsigned CHANNELS = ptcm_pkg::CHANNELS_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] bus_data
    input  wire  [1:0]  s_tuser,    // [0] action, [1] port_select
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata     // [14:0] sample_sum, [15] zero
);

    logic                               accept;
    logic                               bus_write;
    logic                               data_write;
    logic                               is_tick;
    logic [ptcm_pkg::ADDR_W-1:0]        addr_reg, addr_next;
    logic                               out_valid_reg;
    logic [ptcm_pkg::SAMPLE_W-1:0]      sample_reg, sample_next;
    logic [ptcm_pkg::AMP_W-1:0]         amp [CHANNELS];

    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign is_tick    = (s_tuser[0] == ptcm_pkg::ACTION_TICK);
    assign bus_write  = (s_tuser[0] == ptcm_pkg::ACTION_BUS);
    assign data_write = bus_write && (s_tuser[1] == ptcm_pkg::PORT_DATA);

    // Latch the register address on an address-port write
    always_comb
    begin
        addr_next = addr_reg;
        if (bus_write && (s_tuser[1] == ptcm_pkg::PORT_ADDR))
        begin
            addr_next = s_tdata[ptcm_pkg::ADDR_W-1:0];
        end
    end

    // Decode the latched address per channel; channels beyond CHANNELS are absent
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_ch
        localparam logic [ptcm_pkg::ADDR_W-1:0] A_LO =
            ptcm_pkg::REG_PERIOD_BASE + ptcm_pkg::ADDR_W'(2 * g);
        localparam logic [ptcm_pkg::ADDR_W-1:0] A_HI = A_LO + ptcm_pkg::ADDR_W'(1);
        localparam logic [ptcm_pkg::ADDR_W-1:0] A_LVL =
            ptcm_pkg::REG_LEVEL_BASE + ptcm_pkg::ADDR_W'(g);

        ptcm_pkg::ch_ctrl_t ctrl;

        always_comb
        begin
            ctrl.tick         = is_tick;
            ctrl.wr_period_lo = data_write && (addr_reg == A_LO);
            ctrl.wr_period_hi = data_write && (addr_reg == A_HI);
            ctrl.wr_mixer     = data_write && (addr_reg == ptcm_pkg::REG_MIXER);
            ctrl.wr_level     = data_write && (addr_reg == A_LVL);
            ctrl.data         = s_tdata;
        end

        ptcm_tone_ch #(
            .CH_INDEX (g)
        ) u_ch (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (accept),
            .ctrl     (ctrl),
            .amp_next (amp[g])
        );
    end

    // Mix the post-update amplitudes of all channels
    always_comb
    begin
        sample_next = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            sample_next = sample_next + ptcm_pkg::SAMPLE_W'(amp[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                addr_reg      <= addr_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the sample while the output is stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, sample_reg};

endmodule

`default_nettype wire

[src/ptcm_tone_ch.sv]
// ============================================================================
// ptcm_tone_ch - one square-wave tone channel
// Period, down counter, square level, disable bit and volume of one channel;
// presents the amplitude that the channel contributes after the update.
// ============================================================================
`default_nettype none

module ptcm_tone_ch #(
    parameter int unsigned CH_INDEX = 0
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  en,
    input  ptcm_pkg::ch_ctrl_t                   ctrl,
    output logic [ptcm_pkg::AMP_W-1:0]           amp_next
);

    logic [ptcm_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [ptcm_pkg::PERIOD_W-1:0] count_reg, count_next;
    logic                          square_reg, square_next;
    logic                          disable_reg, disable_next;
    logic [ptcm_pkg::LEVEL_W-1:0]  level_reg, level_next;

    always_comb
    begin
        period_next  = period_reg;
        count_next   = count_reg;
        square_next  = square_reg;
        disable_next = disable_reg;
        level_next   = level_reg;

        if (ctrl.wr_period_lo)
        begin
            period_next = {period_reg[ptcm_pkg::PERIOD_W-1:ptcm_pkg::DATA_W], ctrl.data};
        end
        if (ctrl.wr_period_hi)
        begin
            period_next = {ctrl.data[3:0], period_reg[ptcm_pkg::DATA_W-1:0]};
        end
        if (ctrl.wr_mixer)
        begin
            disable_next = ctrl.data[CH_INDEX];
        end
        if (ctrl.wr_level)
        begin
            level_next = ctrl.data[ptcm_pkg::LEVEL_W-1:0];
        end

        // Reload and toggle when the count has run out; zero period acts as one
        if (ctrl.tick)
        begin
            if (count_reg <= ptcm_pkg::PERIOD_W'(1))
            begin
                count_next  = (period_reg == '0) ? ptcm_pkg::PERIOD_W'(1) : period_reg;
                square_next = ~square_reg;
            end
            else
            begin
                count_next = count_reg - ptcm_pkg::PERIOD_W'(1);
            end
        end

        amp_next = (disable_next || square_next) ? ptcm_pkg::vol_rom(level_next) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= '0;
            count_reg   <= '0;
            square_reg  <= 1'b0;
            disable_reg <= 1'b0;
            level_reg   <= '0;
        end
        else if (en)
        begin
            period_reg  <= period_next;
            count_reg   <= count_next;
            square_reg  <= square_next;
            disable_reg <= disable_next;
            level_reg   <= level_next;
        end
    end

endmodule

`default_nettype wire

[src/ptcm_checker.sv]
// ============================================================================
// ptcm_checker - port-level checks for the tone channel mixer
// Watches the stream ports over time; bound to the top level.
// ============================================================================
`default_nettype none

module ptcm_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata
);

    // Input side is held off only by a stalled, full output register
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output register state");

    // Every input transfer produces a sample on the next cycle
    a_transfer_gives_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("input transfer produced no sample");

    // A stalled sample holds its value
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled sample changed or vanished");

    // Three full-scale channels sum to at most 24576
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[15] && (m_tdata[14:0] <= 15'd24576)))
        else $error("mixed sample out of range");

    // Without a new transfer a drained output stays empty
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!(s_tvalid && s_tready) && (!m_tvalid || m_tready)) |=> !m_tvalid)
        else $error("sample appeared without an input transfer");

endmodule

bind psg_tone_channel_mixer ptcm_checker u_ptcm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/psg_tone_channel_mixer_checker.sv]
// ============================================================================
// psg_tone_channel_mixer_checker - sample predictor and scoreboard
// Watches both stream channels, models the tone channels on every input
// transfer and compares each output transfer against the oldest prediction.
// ============================================================================

module psg_tone_channel_mixer_checker #(
    parameter int unsigned CHANNELS = ptcm_pkg::CHANNELS_DEFAULT
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               s_tvalid,
    input  wire               s_tready,
    input  wire  [7:0]        s_tdata,    // [7:0] bus_data
    input  wire  [1:0]        s_tuser,    // [0] action, [1] port_select
    input  wire               m_tvalid,
    input  wire               m_tready,
    input  wire  [15:0]       m_tdata,    // [14:0] sample_sum, [15] zero
    output int unsigned       mismatches,
    output int unsigned       pending
);
    import ptcm_pkg::*;

    // 3 dB steps, rounded
    localparam logic [13:0] LEVEL_AMPLITUDE [16] = '{
        14'd0,    14'd64,   14'd91,   14'd128,  14'd181,  14'd256,  14'd362,  14'd512,
        14'd724,  14'd1024, 14'd1448, 14'd2048, 14'd2896, 14'd4096, 14'd5793, 14'd8192
    };

    logic [ADDR_W-1:0]   addr_latch;
    logic [PERIOD_W-1:0] period   [MAX_CHANNELS];
    logic [PERIOD_W-1:0] count    [MAX_CHANNELS];
    logic                square   [MAX_CHANNELS];
    logic                tone_off [MAX_CHANNELS];
    logic [LEVEL_W-1:0]  level    [MAX_CHANNELS];

    logic [SAMPLE_W-1:0] expected_samples [$];
    logic [SAMPLE_W-1:0] want;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        mismatches++;
        $display("[%0t] mixer output mismatch: %s (got %0d, want %0d)",
                 $time, what, got, exp_val);
    endtask

    task automatic store_register(input logic [ADDR_W-1:0] addr, input logic [7:0] data);
        int ch;
        if (addr < REG_PERIOD_BASE + 2 * MAX_CHANNELS)
        begin
            ch = int'((addr - REG_PERIOD_BASE) >> 1);
            if (ch < CHANNELS)
            begin
                if (addr[0] == 1'b0)
                    period[ch][7:0] = data;
                else
                    period[ch][11:8] = data[3:0];
            end
        end
        else if (addr == REG_MIXER)
        begin
            for (ch = 0; ch < MAX_CHANNELS; ch++)
                if (ch < CHANNELS)
                    tone_off[ch] = data[ch];
        end
        else if (addr >= REG_LEVEL_BASE && addr < REG_LEVEL_BASE + MAX_CHANNELS)
        begin
            ch = int'(addr - REG_LEVEL_BASE);
            if (ch < CHANNELS)
                level[ch] = data[3:0];
        end
    endtask

    task automatic advance_tones();
        for (int ch = 0; ch < MAX_CHANNELS; ch++)
        begin
            if (ch < CHANNELS)
            begin
                if (count[ch] <= 1)
                begin
                    count[ch]  = (period[ch] == '0) ? PERIOD_W'(1) : period[ch];
                    square[ch] = ~square[ch];
                end
                else
                    count[ch] = count[ch] - 1'b1;
            end
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] mix_channels();
        int unsigned sum;
        sum = 0;
        for (int ch = 0; ch < MAX_CHANNELS; ch++)
            if (ch < CHANNELS && (tone_off[ch] || square[ch]))
                sum += 32'(LEVEL_AMPLITUDE[level[ch]]);
        return sum[SAMPLE_W-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mismatches = 0;
            pending    = 0;
            addr_latch = '0;
            expected_samples.delete();
            for (int ch = 0; ch < MAX_CHANNELS; ch++)
            begin
                period[ch]   = '0;
                count[ch]    = '0;
                square[ch]   = 1'b0;
                tone_off[ch] = 1'b0;
                level[ch]    = '0;
            end
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch("sample with none outstanding", m_tdata, 16'd0);
                else
                begin
                    want = expected_samples.pop_front();
                    if (m_tdata[SAMPLE_W-1:0] !== want)
                        report_mismatch("sample_sum", m_tdata, {1'b0, want});
                    if (m_tdata[15] !== 1'b0)
                        report_mismatch("pad bit", m_tdata, {1'b0, want});
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == ACTION_TICK)
                    advance_tones();
                else if (s_tuser[1] == PORT_ADDR)
                    addr_latch = s_tdata[ADDR_W-1:0];
                else
                    store_register(addr_latch, s_tdata);
                expected_samples.push_back(mix_channels());
            end
            pending = expected_samples.size();
        end
    end

endmodule

[tb/tb_psg_tone_channel_mixer.sv]
// ============================================================================
// tb_psg_tone_channel_mixer - stimulus and verdict for the tone mixer
// Programs periods, disable bits and volumes over the bus port, runs ticks
// through random idling phases and a long output stall, and leaves the
// checking to the checker instance.
// ============================================================================

module tb_psg_tone_channel_mixer;
    import ptcm_pkg::*;

    localparam int unsigned CHANNELS    = CHANNELS_DEFAULT;
    localparam int unsigned ITEMS       = 1350;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLDOFF     = 80;

    // Registers outside the map
    localparam logic [ADDR_W-1:0] REG_SPARE   = 4'd6;
    localparam logic [ADDR_W-1:0] REG_PAST_LV = 4'd11;
    localparam logic [ADDR_W-1:0] REG_LAST    = 4'd15;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] bus_data
    logic [1:0]  s_tuser;     // [0] action, [1] port_select
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // [14:0] sample_sum, [15] zero

    int unsigned mismatches;
    int unsigned pending;
    int unsigned items_sent;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned phase;
    int unsigned cycles;

    psg_tone_channel_mixer #(
        .CHANNELS (CHANNELS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    psg_tone_channel_mixer_checker #(
        .CHANNELS (CHANNELS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: abandon the run if the handshakes stop making progress
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[psg_tone_channel_mixer] ERROR");
        $finish;
    end

    // Output side: random back-pressure at the current phase's rate. On
    // entering the last phase, hold tready low for a long stretch while the
    // sender keeps offering, so the output register fills and s_tready drops.
    initial
    begin
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase == 2 && !held)
            begin
                held      = 1'b1;
                hold_left = HOLDOFF;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one transfer, idling first at the sender's rate. Check tready on
    // the falling edge, where it is settled; the transfer then completes at
    // the next rising edge.
    task automatic send_item(input logic act, input logic port, input logic [7:0] data);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {port, act};
        s_tdata  <= data;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    // Address latch followed by a data write: the normal register access
    task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [7:0] data);
        send_item(ACTION_BUS, PORT_ADDR, {4'($urandom_range(15)), addr});
        send_item(ACTION_BUS, PORT_DATA, data);
    endtask

    // Port and data are don't-care on a tick; drive them at random
    task automatic send_tick();
        send_item(ACTION_TICK, 1'($urandom_range(1)), 8'($urandom));
    endtask

    // Keep most periods short so the square waves actually toggle
    function automatic logic [7:0] pick_data(input logic [ADDR_W-1:0] addr);
        if (addr < REG_SPARE && addr[0])
            return ($urandom_range(7) == 0) ? 8'($urandom) : {4'($urandom_range(15)), 4'h0};
        else if (addr < REG_SPARE)
            return ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(12));
        else
            return 8'($urandom);
    endfunction

    task automatic set_phase(input int unsigned p);
        phase = p;
        case (p)
            0:
            begin
                tx_idle_pct = 21;
                rx_idle_pct = 56;
            end
            1:
            begin
                tx_idle_pct = 56;
                rx_idle_pct = 21;
            end
            default:
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    initial
    begin
        logic [ADDR_W-1:0] addr;
        int unsigned       pick;
        int unsigned       wait_left;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        items_sent = 0;
        set_phase(0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick with counters still at zero after reset
        send_item(ACTION_TICK, PORT_DATA, 8'hFF);
        // Volumes at the extremes; upper nibble of data and address ignored
        write_register(REG_LEVEL_BASE, 8'hFF);
        write_register(REG_LEVEL_BASE + 4'd1, 8'hF1);
        write_register(REG_LEVEL_BASE + 4'd2, 8'h0E);
        // Disable channel 1 only; bits above 2 are ignored
        write_register(REG_MIXER, 8'hFA);
        send_item(ACTION_TICK, PORT_ADDR, 8'h00);
        // Longest period on channel 0, zero period on channel 1
        write_register(REG_PERIOD_BASE, 8'hFF);
        write_register(REG_PERIOD_BASE + 4'd1, 8'hFF);
        write_register(REG_PERIOD_BASE + 4'd3, 8'hF0);
        // Unused registers must leave everything alone
        write_register(REG_SPARE, 8'h55);
        write_register(REG_PAST_LV, 8'hAA);
        send_item(ACTION_BUS, PORT_ADDR, {4'h0, REG_LAST});
        send_item(ACTION_BUS, PORT_DATA, 8'hFF);
        send_tick();
        send_tick();
        write_register(REG_MIXER, 8'h07);

        // Random: mostly well-formed register accesses and ticks, some noise
        while (items_sent < ITEMS)
        begin
            if (items_sent * 3 / ITEMS != phase)
                set_phase(items_sent * 3 / ITEMS);
            pick = $urandom_range(99);
            if (pick < 45)
                send_tick();
            else if (pick < 88)
            begin
                addr = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                : 4'($urandom_range(10));
                write_register(addr, pick_data(addr));
            end
            else
                send_item(ACTION_BUS, 1'($urandom_range(1)), 8'($urandom));
        end
        s_tvalid <= 1'b0;

        // Drain outstanding samples, then wait out the output register
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        wait_left = 4;
        while (wait_left != 0)
        begin
            @(posedge clk);
            wait_left--;
        end

        if (mismatches == 0 && pending == 0)
            $display("[psg_tone_channel_mixer] OK");
        else
            $display("[psg_tone_channel_mixer] ERROR");
        $finish;
    end

endmodule

[files.f]
src/ptcm_pkg.sv
src/ptcm_tone_ch.sv
src/psg_tone_channel_mixer.sv
src/ptcm_checker.sv
tb/psg_tone_channel_mixer_checker.sv
tb/tb_psg_tone_channel_mixer.sv
